@@ hdl/hwr_pkg.sv @@
// Shared types and constants for the histogram engine with ranking.
`timescale 1ns / 1ps
package hwr_pkg;

    localparam int NUM_BINS_DEF = 64;
    localparam int CNT_W        = 32;
    localparam int TOT_W        = 38;
    localparam int IDX_W        = 6;
    localparam int CFG_W        = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef enum logic [2:0] {
        OP_COUNT   = 3'd0,
        OP_READ    = 3'd1,
        OP_SUMMARY = 3'd2,
        OP_DUMP    = 3'd3,
        OP_CLEAR   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_DUMP
    } state_t;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [IDX_W-1:0] bin;
    } in_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] bin;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0] bin_index;
        logic [CNT_W-1:0] count_value;
        logic [TOT_W-1:0] total_count;
        logic [IDX_W-1:0] max_index;
        logic [CNT_W-1:0] max_count;
        logic [IDX_W-1:0] min_index;
        logic [CNT_W-1:0] min_count;
        logic             status;
        logic             last;
    } out_t;

endpackage

@@ hdl/histogram_with_ranking.sv @@
// Histogram engine with ranking: top level.
// Count/read: a RAM read, then (for a count) the write-back; the result is registered.
// Summary: one bin per cycle through the RAM read port.
// Dump: n scans of n bins; one result per scan, receiver cannot stall.
// Reset: store cleared at once through per-bin valid flags, bins_in_use = 64, queue empty.
`timescale 1ns / 1ps
module histogram_with_ranking #(
    parameter int NUM_BINS = hwr_pkg::NUM_BINS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  hwr_pkg::in_t              item,
    input  logic                      cfg_we,
    input  logic [hwr_pkg::CFG_W-1:0] cfg_wdata,
    output logic                      result_valid,
    output hwr_pkg::out_t             result
);

    logic          q_valid;
    logic          q_pop;
    hwr_pkg::cmd_t q_cmd;

    hwr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item    (item),
        .busy    (busy),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    hwr_back #(.NUM_BINS(NUM_BINS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

@@ hdl/hwr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hwr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/hwr_front.sv @@
// Front end: accepts transactions, drops unknown opcodes, two-entry command queue.
`timescale 1ns / 1ps
module hwr_front (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  hwr_pkg::in_t item,
    output logic         busy,
    output logic         q_valid,
    output hwr_pkg::cmd_t q_cmd,
    input  logic         q_pop
);

    hwr_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    logic       known_op;
    hwr_pkg::cmd_t new_cmd;

    always_comb
    begin
        known_op = (item.opcode <= 3'(hwr_pkg::OP_CLEAR));
        push     = start && !busy && known_op;
        new_cmd.op  = hwr_pkg::op_t'(item.opcode);
        new_cmd.bin = item.bin;
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(q_pop);
    end

    assign busy    = (fill_reg == 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

@@ hdl/hwr_back.sv @@
// Back end: bin store, count/read, clear, summary scan and selection-sort dump.
`timescale 1ns / 1ps
module hwr_back #(
    parameter int NUM_BINS = hwr_pkg::NUM_BINS_DEF,
    localparam int AW = $clog2(NUM_BINS)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [hwr_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                       q_valid,
    input  hwr_pkg::cmd_t              q_cmd,
    output logic                       q_pop,
    output logic                       result_valid,
    output hwr_pkg::out_t              result
);

    localparam logic [hwr_pkg::CNT_W-1:0] CNT_MAX = '1;
    localparam logic [hwr_pkg::CFG_W-1:0] NB = hwr_pkg::CFG_W'(NUM_BINS);

    hwr_pkg::state_t state_reg, state_next;
    logic [hwr_pkg::CFG_W-1:0] cfg_reg, cfg_next;
    logic [NUM_BINS-1:0]       valid_reg, valid_next;
    logic [NUM_BINS-1:0]       done_reg, done_next;
    logic [hwr_pkg::TOT_W-1:0] total_reg, total_next;
    hwr_pkg::cmd_t             cmd_reg, cmd_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic [hwr_pkg::CFG_W-1:0] rank_reg, rank_next;
    logic                      have_reg, have_next;
    logic [AW-1:0]             bidx_reg, bidx_next;
    logic [hwr_pkg::CNT_W-1:0] bcnt_reg, bcnt_next;
    logic [AW-1:0]             mnidx_reg, mnidx_next;
    logic [hwr_pkg::CNT_W-1:0] mncnt_reg, mncnt_next;
    logic                      rvalid_reg;
    hwr_pkg::out_t             out_reg, out_next;
    logic                      strobe_reg, strobe_next;

    logic [hwr_pkg::CFG_W-1:0] n;
    logic [hwr_pkg::CFG_W-1:0] n_last;
    logic                      at_end;
    logic                      we;
    logic [AW-1:0]             waddr, raddr;
    logic [hwr_pkg::CNT_W-1:0] wdata, rdata, d;
    logic                      take;
    logic [AW-1:0]             pick_idx;
    logic [hwr_pkg::CNT_W-1:0] pick_cnt;

    hwr_ram #(.WIDTH(hwr_pkg::CNT_W), .DEPTH(NUM_BINS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        if (cfg_reg == '0)
            n = hwr_pkg::CFG_W'(1);
        else if (cfg_reg > NB)
            n = NB;
        else
            n = cfg_reg;
        n_last = n - hwr_pkg::CFG_W'(1);
        at_end = (hwr_pkg::CFG_W'(idx_reg) == n_last);
        d      = rvalid_reg ? rdata : '0;

        state_next  = state_reg;
        cfg_next    = cfg_reg;
        valid_next  = valid_reg;
        done_next   = done_reg;
        total_next  = total_reg;
        cmd_next    = cmd_reg;
        idx_next    = idx_reg;
        rank_next   = rank_reg;
        have_next   = have_reg;
        bidx_next   = bidx_reg;
        bcnt_next   = bcnt_reg;
        mnidx_next  = mnidx_reg;
        mncnt_next  = mncnt_reg;
        out_next    = '0;
        out_next.total_count = total_reg;
        out_next.last        = 1'b1;
        strobe_next = 1'b0;
        q_pop       = 1'b0;
        we          = 1'b0;
        waddr       = q_cmd.bin[AW-1:0];
        wdata       = '0;
        raddr       = '0;
        take        = 1'b0;
        pick_idx    = bidx_reg;
        pick_cnt    = bcnt_reg;

        case (state_reg)
            hwr_pkg::S_IDLE:
            begin
                if (cfg_we)
                begin
                    cfg_next   = cfg_wdata;
                    valid_next = '0;
                    total_next = '0;
                end
                else if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    raddr    = q_cmd.bin[AW-1:0];
                    case (q_cmd.op)
                        hwr_pkg::OP_COUNT, hwr_pkg::OP_READ:
                        begin
                            if ({1'b0, q_cmd.bin} < n)
                            begin
                                state_next = hwr_pkg::S_READ;
                            end
                            else
                            begin
                                out_next.bin_index = q_cmd.bin;
                                out_next.status    = 1'b1;
                                strobe_next        = 1'b1;
                            end
                        end
                        hwr_pkg::OP_SUMMARY:
                        begin
                            raddr      = '0;
                            idx_next   = '0;
                            state_next = hwr_pkg::S_SUM;
                        end
                        hwr_pkg::OP_DUMP:
                        begin
                            raddr      = '0;
                            idx_next   = '0;
                            rank_next  = '0;
                            have_next  = 1'b0;
                            done_next  = '0;
                            state_next = hwr_pkg::S_DUMP;
                        end
                        hwr_pkg::OP_CLEAR:
                        begin
                            valid_next           = '0;
                            total_next           = '0;
                            out_next.total_count = '0;
                            strobe_next          = 1'b1;
                        end
                        default:
                        begin
                            state_next = hwr_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            hwr_pkg::S_READ:
            begin
                waddr              = cmd_reg.bin[AW-1:0];
                out_next.bin_index = cmd_reg.bin;
                out_next.count_value = d;
                if (cmd_reg.op == hwr_pkg::OP_COUNT)
                begin
                    we    = 1'b1;
                    wdata = (d == CNT_MAX) ? d : d + 1'b1;
                    valid_next[cmd_reg.bin[AW-1:0]] = 1'b1;
                    if (d != CNT_MAX)
                        total_next = total_reg + 1'b1;
                    out_next.count_value = wdata;
                    out_next.total_count = total_next;
                end
                strobe_next = 1'b1;
                state_next  = hwr_pkg::S_IDLE;
            end

            hwr_pkg::S_SUM:
            begin
                if (idx_reg == '0 || d > bcnt_reg)
                begin
                    pick_idx = idx_reg;
                    pick_cnt = d;
                end
                bidx_next  = pick_idx;
                bcnt_next  = pick_cnt;
                if (idx_reg == '0 || d < mncnt_reg)
                begin
                    mnidx_next = idx_reg;
                    mncnt_next = d;
                end
                if (at_end)
                begin
                    out_next.max_index = hwr_pkg::IDX_W'(pick_idx);
                    out_next.max_count = pick_cnt;
                    out_next.min_index = hwr_pkg::IDX_W'(mnidx_next);
                    out_next.min_count = mncnt_next;
                    strobe_next        = 1'b1;
                    state_next         = hwr_pkg::S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    raddr    = idx_next;
                end
            end

            hwr_pkg::S_DUMP:
            begin
                take = !done_reg[idx_reg] && (!have_reg || d > bcnt_reg);
                if (take)
                begin
                    pick_idx = idx_reg;
                    pick_cnt = d;
                end
                bidx_next = pick_idx;
                bcnt_next = pick_cnt;
                have_next = have_reg || take;
                if (at_end)
                begin
                    done_next[pick_idx]  = 1'b1;
                    out_next.bin_index   = hwr_pkg::IDX_W'(pick_idx);
                    out_next.count_value = pick_cnt;
                    out_next.last        = (rank_reg == n_last);
                    strobe_next          = 1'b1;
                    rank_next            = rank_reg + 1'b1;
                    have_next            = 1'b0;
                    idx_next             = '0;
                    raddr                = '0;
                    if (rank_reg == n_last)
                        state_next = hwr_pkg::S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    raddr    = idx_next;
                end
            end

            default:
            begin
                state_next = hwr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hwr_pkg::S_IDLE;
            cfg_reg    <= hwr_pkg::CFG_RESET;
            valid_reg  <= '0;
            total_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cfg_reg    <= cfg_next;
            valid_reg  <= valid_next;
            total_reg  <= total_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        done_reg   <= done_next;
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        rank_reg   <= rank_next;
        have_reg   <= have_next;
        bidx_reg   <= bidx_next;
        bcnt_reg   <= bcnt_next;
        mnidx_reg  <= mnidx_next;
        mncnt_reg  <= mncnt_next;
        rvalid_reg <= valid_reg[raddr];
        out_reg    <= out_next;
    end

    assign result_valid = strobe_reg;
    assign result       = out_reg;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the histogram engine with bin ranking.
`timescale 1ns / 1ps
module testbench;

    localparam int NBINS = hwr_pkg::NUM_BINS_DEF;
    localparam logic [2:0] FIRST_UNUSED_OP = 3'd5;
    localparam logic [2:0] MID_UNUSED_OP   = 3'd6;
    localparam logic [2:0] LAST_UNUSED_OP  = 3'd7;
    localparam logic [hwr_pkg::CNT_W-1:0] CNT_SAT = '1;
    localparam int MAX_REPORTS = 10;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    hwr_pkg::in_t                 item;
    logic                         cfg_we;
    logic [hwr_pkg::CFG_W-1:0]    cfg_wdata;
    logic                         result_valid;
    hwr_pkg::out_t                result;

    logic [hwr_pkg::CNT_W-1:0]    tally [NBINS];
    int unsigned                  active_bins;
    hwr_pkg::out_t                pending_results [$];
    int unsigned                  mismatches;
    int unsigned                  items_sent;
    int unsigned                  results_seen;
    int unsigned                  dumps_sent;
    int unsigned                  configs_written;
    bit                           no_gaps;

    histogram_with_ranking u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("Timeout");
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [hwr_pkg::TOT_W-1:0] active_total();
        logic [hwr_pkg::TOT_W-1:0] s;
        s = '0;
        for (int i = 0; i < active_bins; i++)
            s += tally[i];
        return s;
    endfunction

    function automatic void store_config(logic [hwr_pkg::CFG_W-1:0] v);
        active_bins = (v < 1) ? 1 : ((v > NBINS) ? NBINS : v);
        foreach (tally[i])
            tally[i] = '0;
    endfunction

    function automatic void queue_result(hwr_pkg::out_t r);
        pending_results = {pending_results, r};
    endfunction

    // predict results of one accepted transaction
    function automatic void predict_histogram(hwr_pkg::in_t x);
        hwr_pkg::out_t r;
        hwr_pkg::out_t ranked [NBINS];
        int unsigned rank;
        int unsigned mx;
        int unsigned mn;
        r = '0;
        r.total_count = active_total();
        r.last = 1'b1;
        case (x.opcode)
            hwr_pkg::OP_COUNT:
            begin
                r.bin_index = x.bin;
                if (x.bin >= active_bins)
                    r.status = 1'b1;
                else
                begin
                    if (tally[x.bin] != CNT_SAT)
                        tally[x.bin]++;
                    r.count_value = tally[x.bin];
                    r.total_count = active_total();
                end
                queue_result(r);
            end
            hwr_pkg::OP_READ:
            begin
                r.bin_index = x.bin;
                if (x.bin >= active_bins)
                    r.status = 1'b1;
                else
                    r.count_value = tally[x.bin];
                queue_result(r);
            end
            hwr_pkg::OP_SUMMARY:
            begin
                mx = 0;
                mn = 0;
                for (int i = 1; i < active_bins; i++)
                begin
                    if (tally[i] > tally[mx]) mx = i;
                    if (tally[i] < tally[mn]) mn = i;
                end
                r.max_index = hwr_pkg::IDX_W'(mx);
                r.max_count = tally[mx];
                r.min_index = hwr_pkg::IDX_W'(mn);
                r.min_count = tally[mn];
                queue_result(r);
            end
            hwr_pkg::OP_DUMP:
            begin
                for (int i = 0; i < active_bins; i++)
                begin
                    rank = 0;
                    for (int j = 0; j < active_bins; j++)
                        if (tally[j] > tally[i] || (tally[j] == tally[i] && j < i))
                            rank++;
                    ranked[rank] = r;
                    ranked[rank].bin_index = hwr_pkg::IDX_W'(i);
                    ranked[rank].count_value = tally[i];
                    ranked[rank].last = (rank == active_bins - 1);
                end
                for (int k = 0; k < active_bins; k++)
                    queue_result(ranked[k]);
            end
            hwr_pkg::OP_CLEAR:
            begin
                foreach (tally[i])
                    tally[i] = '0;
                r.total_count = '0;
                queue_result(r);
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(logic [2:0] op, logic [hwr_pkg::IDX_W-1:0] b);
        hwr_pkg::in_t x;
        int unsigned gap;
        x.opcode = op;
        x.bin = b;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= x;
        do
            @(posedge clk);
        while (busy);
        predict_histogram(x);
        items_sent++;
        if (op == hwr_pkg::OP_DUMP)
            dumps_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        do
            @(posedge clk);
        while (busy);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_bins(logic [hwr_pkg::CFG_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        store_config(v);
        configs_written++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected transaction: %p", result);
            end
            else
            begin
                hwr_pkg::out_t e;
                e = pending_results.pop_front();
                if (result !== e)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("Mismatch at %0t", $realtime);
                        $display("  expected %p", e);
                        $display("  actual   %p", result);
                    end
                end
            end
        end
    end

    task automatic test_after_reset();
        send_item(hwr_pkg::OP_READ, 6'd0);
        send_item(hwr_pkg::OP_READ, 6'd63);
        send_item(hwr_pkg::OP_SUMMARY, 6'd0);
        send_item(hwr_pkg::OP_DUMP, 6'd0);
    endtask

    task automatic test_directed_ops();
        send_item(hwr_pkg::OP_COUNT, 6'd63);
        send_item(hwr_pkg::OP_COUNT, 6'd0);
        send_item(hwr_pkg::OP_COUNT, 6'd63);
        send_item(hwr_pkg::OP_COUNT, 6'd42);
        send_item(hwr_pkg::OP_COUNT, 6'd21);
        send_item(hwr_pkg::OP_READ, 6'd63);
        send_item(hwr_pkg::OP_SUMMARY, 6'd0);
        send_item(hwr_pkg::OP_DUMP, 6'd0);
        send_item(FIRST_UNUSED_OP, 6'd7);
        send_item(MID_UNUSED_OP, 6'd56);
        send_item(LAST_UNUSED_OP, 6'd63);
        send_item(hwr_pkg::OP_CLEAR, 6'd0);
        send_item(hwr_pkg::OP_SUMMARY, 6'd0);
    endtask

    task automatic test_narrow_range();
        write_bins(7'd3);
        send_item(hwr_pkg::OP_COUNT, 6'd2);
        send_item(hwr_pkg::OP_COUNT, 6'd3);
        send_item(hwr_pkg::OP_READ, 6'd63);
        send_item(hwr_pkg::OP_COUNT, 6'd1);
        send_item(hwr_pkg::OP_COUNT, 6'd2);
        send_item(hwr_pkg::OP_SUMMARY, 6'd0);
        send_item(hwr_pkg::OP_DUMP, 6'd0);
    endtask

    task automatic test_random_phase(logic [hwr_pkg::CFG_W-1:0] v, int unsigned count);
        int unsigned sel;
        int unsigned hot;
        write_bins(v);
        no_gaps = ($urandom_range(0, 2) == 0);
        hot = (active_bins < 6) ? active_bins : $urandom_range(3, 6);
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
                send_item(hwr_pkg::OP_COUNT, hwr_pkg::IDX_W'($urandom_range(0, hot - 1)));
            else if (sel < 62)
                send_item(hwr_pkg::OP_COUNT, hwr_pkg::IDX_W'($urandom_range(0, 63)));
            else if (sel < 72)
                send_item(hwr_pkg::OP_READ, hwr_pkg::IDX_W'($urandom_range(0, 63)));
            else if (sel < 82)
                send_item(hwr_pkg::OP_SUMMARY, hwr_pkg::IDX_W'($urandom_range(0, 63)));
            else if (sel < 88)
                send_item(hwr_pkg::OP_DUMP, hwr_pkg::IDX_W'($urandom_range(0, 63)));
            else if (sel < 93)
                send_item(hwr_pkg::OP_CLEAR, hwr_pkg::IDX_W'($urandom_range(0, 63)));
            else
                send_item(3'($urandom_range(FIRST_UNUSED_OP, LAST_UNUSED_OP)),
                          hwr_pkg::IDX_W'($urandom_range(0, 63)));
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        item <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        dumps_sent = 0;
        configs_written = 0;
        no_gaps = 1'b0;
        store_config(hwr_pkg::CFG_RESET);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_directed_ops();
        test_narrow_range();
        test_random_phase(7'd1, 12);
        test_random_phase(7'd0, 8);
        test_random_phase(7'd2, 15);
        test_random_phase(7'd64, 12);
        test_random_phase(7'd127, 15);
        test_random_phase(7'd100, 10);
        test_random_phase(7'd85, 10);
        test_random_phase(hwr_pkg::CFG_W'($urandom_range(4, 40)), 15);
        test_random_phase(hwr_pkg::CFG_W'($urandom_range(0, 127)), 10);

        drain();
        repeat (50) @(posedge clk);
        $display("Sent %0d transactions (%0d sorted dumps), checked %0d results,",
                 items_sent, dumps_sent, results_seen);
        $display("over %0d bin-count settings; %0d mismatches.", configs_written, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ files.f @@
hdl/hwr_pkg.sv
hdl/hwr_ram.sv
hdl/hwr_front.sv
hdl/hwr_back.sv
hdl/histogram_with_ranking.sv
tb/sv/testbench.sv
